[rtl/pltbe_pkg.sv]
// Shared constants and types of the path length, turn and battery estimator.
`default_nettype none
package pltbe_pkg;

    localparam int COORD_WIDTH_DEF      = 32;
    localparam int TURN_COUNT_WIDTH_DEF = 24;

    localparam int DIST_W     = 48;
    localparam int PCT_W      = 40;
    localparam int NUM_W      = 80;
    localparam int DEN_W      = 32;
    localparam int SPEED_W    = 24;
    localparam int RESERVE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [28:0] COS1_Q28    = 29'd268394572;
    localparam logic [22:0] HUNDRED_Q16 = 23'd6553600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED,
        CFG_TURN_SEC,
        CFG_TOL_SEC,
        CFG_USABLE,
        CFG_RESERVE,
        CFG_CAPACITY
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_ROOT_GO,
        S_ROOT,
        S_DOT_A,
        S_DOT_B,
        S_DOT_C,
        S_LEN_P,
        S_COS_LO,
        S_COS_HI,
        S_CMP,
        S_UPD,
        S_LATCH,
        S_F_TURN,
        S_F_TURNP,
        S_F_CRUISE,
        S_F_TOTAL,
        S_F_E0,
        S_F_E1,
        S_F_E2,
        S_F_E3,
        S_F_EDIV,
        S_F_UGO,
        S_F_UDIV,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

[rtl/pltbe_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module pltbe_mul #(
    parameter int MW = 34
) (
    input  wire                   i_clk,
    input  wire signed [MW-1:0]   i_a,
    input  wire signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_p
);

    logic signed [2*MW-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= (2*MW)'(i_a) * (2*MW)'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

[rtl/pltbe_sqrt.sv]
// Bit-serial restoring integer square root, one result bit per cycle.
`default_nettype none
module pltbe_sqrt #(
    parameter int RT_W = 33
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire [2*RT_W-1:0]   i_rad,
    output logic               o_busy,
    output logic               o_done,
    output logic [RT_W-1:0]    o_root
);

    localparam int CNT_W = $clog2(RT_W + 1);

    logic [2*RT_W-1:0] r_rad;
    logic [RT_W+1:0]   r_rem;
    logic [RT_W-1:0]   r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RT_W+3:0]   tmp;
    logic [RT_W+3:0]   trial;

    // Bring down two radicand bits and try the next root bit
    assign tmp   = {r_rem, r_rad[2*RT_W-1 -: 2]};
    assign trial = (RT_W+4)'({r_root, 2'b01});

    // Control: count iterations, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift radicand, update remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[2*RT_W-3:0], 2'b00};
            if (tmp >= trial) begin
                r_rem  <= (RT_W+2)'(tmp - trial);
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= tmp[RT_W+1:0];
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

[rtl/pltbe_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pltbe_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [pltbe_pkg::NUM_W-1:0] i_num,
    input  wire [pltbe_pkg::DEN_W-1:0] i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [pltbe_pkg::NUM_W-1:0] o_quot
);

    localparam int NW    = pltbe_pkg::NUM_W;
    localparam int DW    = pltbe_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      tmp;

    // Bring down the next numerator bit
    assign tmp = {r_rem, r_num[NW-1]};

    // Control: count iterations, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (tmp >= {1'b0, r_den}) begin
                r_rem <= DW'(tmp - {1'b0, r_den});
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= tmp[DW-1:0];
                r_num <= {r_num[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

[rtl/path_length_turn_battery_estimator.sv]
// Top level of the path length, turn count and battery estimator.
// Points arrive one transaction at a time as signed Q.16 metre coordinates,
// with tlast on the final point of a path. A later point of a path runs the
// bit-serial square root of COORD_WIDTH+1 iterations, then either no turn
// test, a turn test that the dot product alone settles, or the full turn
// test on the shared multiplier. The last point then adds up to three
// 80-step divisions on the shared divider before the result is offered,
// plus any wait for the result to be taken. The input is not ready while
// a point is being worked on or a result waits on the output. The path state
// clears before the result is offered, and the next point starts a new path.
`default_nettype none
module path_length_turn_battery_estimator #(
    parameter int COORD_WIDTH      = pltbe_pkg::COORD_WIDTH_DEF,
    parameter int TURN_COUNT_WIDTH = pltbe_pkg::TURN_COUNT_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // point_x, point_y
    input  wire [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    input  wire                                s_axis_tlast,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // turn_count, path_distance, cruise_time, turning_time, total_time,
    // energy_used, used_percent, remaining_percent
    output logic [((TURN_COUNT_WIDTH+5*48+2*40+7)/8)*8-1:0] m_axis_tdata,
    // within_reserve
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire                                i_cfg_we,
    input  wire [pltbe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [pltbe_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int TCW  = TURN_COUNT_WIDTH;
    localparam int D_W  = CW + 1;
    localparam int MW   = (CW + 2 > 34) ? CW + 2 : 34;
    localparam int PW   = 2 * MW;
    localparam int RW   = 2 * D_W + 30;
    localparam int SW   = ((D_W > pltbe_pkg::DIST_W) ? D_W : pltbe_pkg::DIST_W) + 1;
    localparam int DSW  = pltbe_pkg::DIST_W;
    localparam int PCW  = pltbe_pkg::PCT_W;
    localparam int NW   = pltbe_pkg::NUM_W;
    localparam int OUT_BITS = TCW + 5*DSW + 2*PCW;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [DSW-1:0] MAX48 = {DSW{1'b1}};
    localparam logic [PCW-1:0] MAX40 = {PCW{1'b1}};
    localparam logic [PCW-1:0] NEG_FLOOR = {1'b1, {(PCW-1){1'b0}}};

    pltbe_pkg::t_state r_state, n_state;

    // Configuration registers
    logic [pltbe_pkg::SPEED_W-1:0]   r_speed;
    logic [31:0]                     r_turn_sec;
    logic [31:0]                     r_tol_sec;
    logic [31:0]                     r_usable;
    logic [pltbe_pkg::RESERVE_W-1:0] r_reserve;
    logic [31:0]                     r_cap;

    // Path state
    logic signed [CW-1:0]  r_prev_x, r_prev_y;
    logic signed [D_W-1:0] r_prev_dx, r_prev_dy;
    logic [D_W-1:0]        r_prev_len;
    logic [1:0]            r_pts;
    logic [DSW-1:0]        r_dist;
    logic [TCW-1:0]        r_turn_total;

    // Working registers of one point
    logic signed [CW-1:0]  r_x, r_y;
    logic                  r_last;
    logic signed [D_W-1:0] r_dx, r_dy;
    logic signed [PW-1:0]  r_acc;
    logic [D_W-1:0]        r_len;
    logic [D_W-1:0]        r_phi;
    logic [RW-1:0]         r_rhs;
    logic                  r_is_turn;

    // Result registers
    logic [TCW-1:0] r_o_turn;
    logic [DSW-1:0] r_o_dist, r_cruise, r_turning, r_total, r_energy;
    logic [PCW-1:0] r_used, r_rem;
    logic           r_within;
    logic [NW-1:0]  r_num;

    // Shared units
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic                 sq_start, sq_busy, sq_done;
    logic [D_W-1:0]       sq_root;
    logic                 div_start, div_busy, div_done;
    logic [NW-1:0]        div_num, div_quot;
    logic [31:0]          div_den;

    logic signed [CW-1:0] in_x, in_y;
    logic                 in_acc, out_acc;
    logic [SW-1:0]        dist_sum;
    logic [DSW+1:0]       total_sum;
    logic [NW-1:0]        total_x100;
    logic [RW-1:0]        dot_lhs;

    assign in_x    = s_axis_tdata[CW-1:0];
    assign in_y    = s_axis_tdata[2*CW-1:CW];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    assign dist_sum   = SW'(r_dist) + SW'(sq_root);
    assign total_sum  = (DSW+2)'(r_cruise) + (DSW+2)'(r_turning) + (DSW+2)'(r_tol_sec);
    assign total_x100 = (NW'(r_total) << 6) + (NW'(r_total) << 5) + (NW'(r_total) << 2);
    assign dot_lhs    = RW'({r_acc[2*D_W-1:0], 28'b0});

    pltbe_mul #(.MW(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pltbe_sqrt #(.RT_W(D_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc[2*D_W-1:0]),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    pltbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pltbe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, handshakes and shared unit operands
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        sq_start      = 1'b0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = r_usable;
        case (r_state)
            pltbe_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (r_pts == 2'd0) ? pltbe_pkg::S_UPD : pltbe_pkg::S_SQX;
                end
            end
            pltbe_pkg::S_SQX: begin
                mul_a   = MW'(r_dx);
                mul_b   = MW'(r_dx);
                n_state = pltbe_pkg::S_SQY;
            end
            pltbe_pkg::S_SQY: begin
                mul_a   = MW'(r_dy);
                mul_b   = MW'(r_dy);
                n_state = pltbe_pkg::S_SQSUM;
            end
            pltbe_pkg::S_SQSUM:   n_state = pltbe_pkg::S_ROOT_GO;
            pltbe_pkg::S_ROOT_GO: begin
                sq_start = 1'b1;
                n_state  = pltbe_pkg::S_ROOT;
            end
            pltbe_pkg::S_ROOT: begin
                if (sq_done) begin
                    if (r_pts == 2'd2 && r_prev_len != '0 && sq_root != '0) begin
                        n_state = pltbe_pkg::S_DOT_A;
                    end else begin
                        n_state = pltbe_pkg::S_UPD;
                    end
                end
            end
            pltbe_pkg::S_DOT_A: begin
                mul_a   = MW'(r_prev_dx);
                mul_b   = MW'(r_dx);
                n_state = pltbe_pkg::S_DOT_B;
            end
            pltbe_pkg::S_DOT_B: begin
                mul_a   = MW'(r_prev_dy);
                mul_b   = MW'(r_dy);
                n_state = pltbe_pkg::S_DOT_C;
            end
            pltbe_pkg::S_DOT_C: begin
                mul_a   = $signed(MW'(r_prev_len));
                mul_b   = $signed(MW'(r_len));
                n_state = pltbe_pkg::S_LEN_P;
            end
            pltbe_pkg::S_LEN_P: begin
                mul_a = $signed(MW'(pltbe_pkg::COS1_Q28));
                mul_b = $signed(MW'(mul_p[D_W-1:0]));
                if (r_acc[PW-1] || r_acc == '0) begin
                    n_state = pltbe_pkg::S_UPD;
                end else begin
                    n_state = pltbe_pkg::S_COS_LO;
                end
            end
            pltbe_pkg::S_COS_LO: begin
                mul_a   = $signed(MW'(pltbe_pkg::COS1_Q28));
                mul_b   = $signed(MW'(r_phi));
                n_state = pltbe_pkg::S_COS_HI;
            end
            pltbe_pkg::S_COS_HI: n_state = pltbe_pkg::S_CMP;
            pltbe_pkg::S_CMP:    n_state = pltbe_pkg::S_UPD;
            pltbe_pkg::S_UPD: begin
                n_state = r_last ? pltbe_pkg::S_LATCH : pltbe_pkg::S_IDLE;
            end
            pltbe_pkg::S_LATCH: n_state = pltbe_pkg::S_F_TURN;
            pltbe_pkg::S_F_TURN: begin
                mul_a     = $signed(MW'(r_o_turn));
                mul_b     = $signed(MW'(r_turn_sec));
                div_num   = NW'({r_o_dist, 16'b0});
                div_den   = 32'(r_speed);
                div_start = (r_speed != '0);
                n_state   = pltbe_pkg::S_F_TURNP;
            end
            pltbe_pkg::S_F_TURNP: n_state = pltbe_pkg::S_F_CRUISE;
            pltbe_pkg::S_F_CRUISE: begin
                if (r_speed == '0 || div_done) begin
                    n_state = pltbe_pkg::S_F_TOTAL;
                end
            end
            pltbe_pkg::S_F_TOTAL: n_state = pltbe_pkg::S_F_E0;
            pltbe_pkg::S_F_E0: begin
                mul_a   = $signed(MW'(r_total[23:0]));
                mul_b   = $signed(MW'(r_cap));
                n_state = pltbe_pkg::S_F_E1;
            end
            pltbe_pkg::S_F_E1: begin
                mul_a   = $signed(MW'(r_total[47:24]));
                mul_b   = $signed(MW'(r_cap));
                n_state = pltbe_pkg::S_F_E2;
            end
            pltbe_pkg::S_F_E2: begin
                mul_a   = $signed(MW'(r_usable));
                mul_b   = $signed(MW'(17'h10000 - 17'(r_reserve)));
                n_state = pltbe_pkg::S_F_E3;
            end
            pltbe_pkg::S_F_E3: begin
                if (r_usable == '0) begin
                    n_state = pltbe_pkg::S_OUT;
                end else begin
                    div_num   = r_num;
                    div_start = 1'b1;
                    n_state   = pltbe_pkg::S_F_EDIV;
                end
            end
            pltbe_pkg::S_F_EDIV: begin
                if (div_done) begin
                    n_state = pltbe_pkg::S_F_UGO;
                end
            end
            pltbe_pkg::S_F_UGO: begin
                div_num   = total_x100 << 16;
                div_start = 1'b1;
                n_state   = pltbe_pkg::S_F_UDIV;
            end
            pltbe_pkg::S_F_UDIV: begin
                if (div_done) begin
                    n_state = pltbe_pkg::S_OUT;
                end
            end
            pltbe_pkg::S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = pltbe_pkg::S_IDLE;
                end
            end
            default: n_state = pltbe_pkg::S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= pltbe_pkg::SPEED_W'(65536);
            r_turn_sec <= '0;
            r_tol_sec  <= '0;
            r_usable   <= 32'd65536;
            r_reserve  <= '0;
            r_cap      <= 32'd65536;
        end else if (i_cfg_we) begin
            case (pltbe_pkg::t_cfg_idx'(i_cfg_idx))
                pltbe_pkg::CFG_SPEED:    r_speed    <= i_cfg_data[pltbe_pkg::SPEED_W-1:0];
                pltbe_pkg::CFG_TURN_SEC: r_turn_sec <= i_cfg_data;
                pltbe_pkg::CFG_TOL_SEC:  r_tol_sec  <= i_cfg_data;
                pltbe_pkg::CFG_USABLE:   r_usable   <= i_cfg_data;
                pltbe_pkg::CFG_RESERVE:  r_reserve  <= i_cfg_data[pltbe_pkg::RESERVE_W-1:0];
                pltbe_pkg::CFG_CAPACITY: r_cap      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Path state: advance on each point, clear once the result is latched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_dx    <= '0;
            r_prev_dy    <= '0;
            r_prev_len   <= '0;
            r_pts        <= '0;
            r_dist       <= '0;
            r_turn_total <= '0;
        end else begin
            case (r_state)
                pltbe_pkg::S_ROOT: begin
                    if (sq_done) begin
                        r_dist <= (dist_sum > SW'(MAX48)) ? MAX48 : dist_sum[DSW-1:0];
                    end
                end
                pltbe_pkg::S_UPD: begin
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                    if (r_pts != 2'd0) begin
                        r_prev_dx  <= r_dx;
                        r_prev_dy  <= r_dy;
                        r_prev_len <= r_len;
                    end
                    if (r_is_turn && !(&r_turn_total)) begin
                        r_turn_total <= r_turn_total + 1'b1;
                    end
                    if (r_pts != 2'd2) begin
                        r_pts <= r_pts + 2'd1;
                    end
                end
                pltbe_pkg::S_LATCH: begin
                    r_prev_x     <= '0;
                    r_prev_y     <= '0;
                    r_prev_dx    <= '0;
                    r_prev_dy    <= '0;
                    r_prev_len   <= '0;
                    r_pts        <= '0;
                    r_dist       <= '0;
                    r_turn_total <= '0;
                end
                default: ;
            endcase
        end
    end

    // Working datapath of one point and of the final result
    always_ff @(posedge i_clk) begin
        case (r_state)
            pltbe_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_x       <= in_x;
                    r_y       <= in_y;
                    r_last    <= s_axis_tlast;
                    r_is_turn <= 1'b0;
                    r_dx      <= D_W'(in_x) - D_W'(r_prev_x);
                    r_dy      <= D_W'(in_y) - D_W'(r_prev_y);
                end
            end
            pltbe_pkg::S_SQY:   r_acc <= mul_p;
            pltbe_pkg::S_SQSUM: r_acc <= r_acc + mul_p;
            pltbe_pkg::S_ROOT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            pltbe_pkg::S_DOT_B: r_acc <= mul_p;
            pltbe_pkg::S_DOT_C: r_acc <= r_acc + mul_p;
            pltbe_pkg::S_LEN_P: begin
                // a dot of zero or below is a turn at once
                if (r_acc[PW-1] || r_acc == '0) begin
                    r_is_turn <= 1'b1;
                end
                r_phi <= mul_p[2*D_W-1:D_W];
            end
            pltbe_pkg::S_COS_LO: r_rhs <= RW'(mul_p[D_W+28:0]);
            pltbe_pkg::S_COS_HI: r_rhs <= r_rhs + (RW'(mul_p[D_W+28:0]) << D_W);
            pltbe_pkg::S_CMP:    r_is_turn <= (dot_lhs < r_rhs);
            pltbe_pkg::S_LATCH: begin
                r_o_turn <= r_turn_total;
                r_o_dist <= r_dist;
            end
            pltbe_pkg::S_F_TURNP: begin
                r_turning <= (mul_p[PW-1:DSW] != '0) ? MAX48 : mul_p[DSW-1:0];
            end
            pltbe_pkg::S_F_CRUISE: begin
                if (r_speed == '0) begin
                    r_cruise <= MAX48;
                end else if (div_done) begin
                    r_cruise <= (div_quot[NW-1:DSW] != '0) ? MAX48 : div_quot[DSW-1:0];
                end
            end
            pltbe_pkg::S_F_TOTAL: begin
                r_total <= (total_sum[DSW+1:DSW] != 2'b00) ? MAX48 : total_sum[DSW-1:0];
            end
            pltbe_pkg::S_F_E1: r_num <= NW'(mul_p[55:0]);
            pltbe_pkg::S_F_E2: r_num <= r_num + (NW'(mul_p[55:0]) << 24);
            pltbe_pkg::S_F_E3: begin
                r_within <= (64'({r_total, 16'b0}) <= 64'(mul_p[48:0]));
                if (r_usable == '0) begin
                    r_energy <= MAX48;
                    r_used   <= MAX40;
                    r_rem    <= NEG_FLOOR;
                end
            end
            pltbe_pkg::S_F_EDIV: begin
                if (div_done) begin
                    r_energy <= (div_quot[NW-1:DSW] != '0) ? MAX48 : div_quot[DSW-1:0];
                end
            end
            pltbe_pkg::S_F_UDIV: begin
                if (div_done) begin
                    r_used <= (div_quot[NW-1:PCW] != '0) ? MAX40 : div_quot[PCW-1:0];
                    if (div_quot > NW'(pltbe_pkg::HUNDRED_Q16) + (NW'(1) << (PCW-1))) begin
                        r_rem <= NEG_FLOOR;
                    end else begin
                        r_rem <= PCW'(pltbe_pkg::HUNDRED_Q16) - div_quot[PCW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // Drive the result transaction
    assign m_axis_tdata = OUT_DW'({r_rem, r_used, r_energy, r_total, r_turning,
                                   r_cruise, r_o_dist, r_o_turn});
    assign m_axis_tuser = r_within;

    // The input never opens while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while result pending");

    // Path state is already clear once a result is offered
    a_path_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pts == 2'd0 && r_dist == '0 && r_turn_total == '0))
        else $error("path state not cleared behind result");

    // Shared units are quiet whenever the block waits for a point
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!div_busy && !sq_busy))
        else $error("shared unit busy while idle");

    // A result completes and the block returns to idle
    a_out_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (r_state == pltbe_pkg::S_IDLE))
        else $error("no return to idle after result");

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the path length, turn count and battery estimator.
`default_nettype none
module testbench;

    localparam int  STALL_LIMIT = 5000;
    localparam int  SETTLE      = 400;
    localparam int  TURN_MAX    = (1 << 24) - 1;
    localparam bit [127:0] MAX48 = 128'hFFFF_FFFF_FFFF;
    localparam bit [127:0] MAX40 = 128'hFF_FFFF_FFFF;
    localparam bit [127:0] COS1  = 128'd268394572;
    localparam bit [127:0] PCT100 = 128'd6553600;

    // Result fields, turn count in the lowest bits
    typedef struct packed {
        bit [39:0] remaining;
        bit [39:0] used;
        bit [47:0] energy;
        bit [47:0] total;
        bit [47:0] turning;
        bit [47:0] cruise;
        bit [47:0] distance;
        bit [23:0] turns;
    } t_estimate;

    typedef struct {
        t_estimate est;
        bit        in_reserve;
    } t_result;

    typedef struct {
        bit [31:0] x;
        bit [31:0] y;
        bit        last;
    } t_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [63:0]  s_axis_tdata = '0;   // point_x, point_y
    logic         s_axis_tlast = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [343:0] m_axis_tdata;        // turn_count .. remaining_percent
    logic         m_axis_tuser;        // within_reserve
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [pltbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [pltbe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    path_length_turn_battery_estimator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_point  pending_points[$];
    t_result expected_estimates[$];
    int      errors = 0;
    bit      calm = 1'b0;
    bit      point_taken = 1'b0;
    int      stall_cycles = 0;

    // Register copies
    bit [127:0] speed, turn_sec, fixed_sec, usable_sec, reserve, capacity;
    // Path state copies
    longint     last_x, last_y, seg_dx, seg_dy;
    bit [127:0] seg_len;
    int         points_in_path;
    bit [127:0] path_sum;
    int         turn_tally;

    function automatic void clear_path();
        last_x = 0; last_y = 0; seg_dx = 0; seg_dy = 0; seg_len = 0;
        points_in_path = 0; path_sum = 0; turn_tally = 0;
    endfunction

    function automatic bit [127:0] int_sqrt(bit [127:0] s);
        bit [127:0] r, c;
        r = 0;
        for (int b = 52; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    // Heading change above one degree between two non-zero segments
    function automatic bit heading_turn(longint ax, longint ay, longint bx, longint by,
                                        bit [127:0] la, bit [127:0] lb);
        logic signed [127:0] dot, wax, way, wbx, wby;
        wax = ax; way = ay; wbx = bx; wby = by;
        dot = wax * wbx + way * wby;
        if (dot <= 0) return 1'b1;
        return (128'(dot) << 28) < COS1 * la * lb;
    endfunction

    function automatic bit [127:0] sat(bit [127:0] v, bit [127:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // Advance the path by one point; queue the estimate on the final point
    function automatic void predict_point(t_point p);
        longint     x, y, dx, dy;
        logic signed [127:0] wdx, wdy;
        bit [127:0] len, cruise, turning, total, uq, energy, used;
        bit [63:0]  lhs, rhs;
        t_result    res;
        x = longint'($signed(p.x));
        y = longint'($signed(p.y));
        if (points_in_path >= 1) begin
            dx = x - last_x;
            dy = y - last_y;
            wdx = dx; wdy = dy;
            len = int_sqrt(128'(wdx * wdx + wdy * wdy));
            path_sum = sat(path_sum + len, MAX48);
            if (points_in_path >= 2 && seg_len != 0 && len != 0 &&
                heading_turn(seg_dx, seg_dy, dx, dy, seg_len, len) && turn_tally < TURN_MAX)
                turn_tally++;
            seg_dx = dx; seg_dy = dy; seg_len = len;
        end
        last_x = x; last_y = y;
        if (points_in_path < 2) points_in_path++;
        if (!p.last) return;

        if (speed == 0) cruise = MAX48;
        else cruise = sat((path_sum << 16) / speed, MAX48);
        turning = sat(128'(turn_tally) * turn_sec, MAX48);
        total   = sat(cruise + turning + fixed_sec, MAX48);
        if (usable_sec == 0) begin
            energy = MAX48;
            used   = MAX40;
            res.est.remaining = 40'h80_0000_0000;
        end else begin
            uq     = total * PCT100 / usable_sec;
            energy = sat(total * capacity / usable_sec, MAX48);
            used   = sat(uq, MAX40);
            if (uq > PCT100 + (128'd1 << 39)) res.est.remaining = 40'h80_0000_0000;
            else begin
                res.est.remaining = 40'(PCT100 - uq);
            end
        end
        res.est.turns    = turn_tally[23:0];
        res.est.distance = path_sum[47:0];
        res.est.cruise   = cruise[47:0];
        res.est.turning  = turning[47:0];
        res.est.total    = total[47:0];
        res.est.energy   = energy[47:0];
        res.est.used     = used[39:0];
        lhs = {total[47:0], 16'b0};
        rhs = 64'(usable_sec * (128'd65536 - reserve));
        res.in_reserve = lhs <= rhs;
        expected_estimates.insert(expected_estimates.size(), res);
        clear_path();
    endfunction

    // Feed points at the falling edge
    always @(negedge i_clk) begin
        t_point p;
        if (i_rst_n && (!s_axis_tvalid || point_taken)) begin
            if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                p = pending_points.pop_front();
                s_axis_tdata  <= {p.y, p.x};
                s_axis_tlast  <= p.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            point_taken = 1'b0;
        end
        m_axis_tready <= i_rst_n && (calm || $urandom_range(99) >= 35);
    end

    // Predict on every accepted point
    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            p.x = s_axis_tdata[31:0];
            p.y = s_axis_tdata[63:32];
            p.last = s_axis_tlast;
            predict_point(p);
            point_taken = 1'b1;
        end
    end

    task automatic check_field(string nm, bit [63:0] e, bit [63:0] a, inout bit bad);
        if (e !== a) begin
            bad = 1'b1;
            if (errors < 10)
                $display("mismatch %s: expected %0h, got %0h", nm, e, a);
        end
    endtask

    // Compare each result transaction with the oldest estimate
    always @(posedge i_clk) begin
        t_result   e;
        t_estimate a;
        bit        bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_estimates.size() == 0) begin
                if (errors < 10) $display("unexpected result transaction");
                errors++;
            end else begin
                e = expected_estimates.pop_front();
                a = m_axis_tdata;
                bad = 1'b0;
                check_field("turn_count", 64'(e.est.turns), 64'(a.turns), bad);
                check_field("path_distance", 64'(e.est.distance), 64'(a.distance), bad);
                check_field("cruise_time", 64'(e.est.cruise), 64'(a.cruise), bad);
                check_field("turning_time", 64'(e.est.turning), 64'(a.turning), bad);
                check_field("total_time", 64'(e.est.total), 64'(a.total), bad);
                check_field("energy_used", 64'(e.est.energy), 64'(a.energy), bad);
                check_field("used_percent", 64'(e.est.used), 64'(a.used), bad);
                check_field("remaining_percent", 64'(e.est.remaining),
                            64'(a.remaining), bad);
                check_field("within_reserve", 64'(e.in_reserve), 64'(m_axis_tuser), bad);
                if (bad) errors++;
            end
        end
    end

    // Abort when no transaction moves while work is outstanding
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_points.size() == 0 && expected_estimates.size() == 0 && !s_axis_tvalid))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic cfg_write(pltbe_pkg::t_cfg_idx idx, bit [31:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            pltbe_pkg::CFG_SPEED:    speed      = v[23:0];
            pltbe_pkg::CFG_TURN_SEC: turn_sec   = v;
            pltbe_pkg::CFG_TOL_SEC:  fixed_sec  = v;
            pltbe_pkg::CFG_USABLE:   usable_sec = v;
            pltbe_pkg::CFG_RESERVE:  reserve    = v[15:0];
            pltbe_pkg::CFG_CAPACITY: capacity   = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(bit [31:0] x, bit [31:0] y, bit last);
        t_point p;
        p.x = x; p.y = y; p.last = last;
        pending_points.insert(pending_points.size(), p);
    endtask

    function automatic int signed_rand(int mag);
        int v;
        v = int'($urandom_range(mag));
        return $urandom_range(1) ? -v : v;
    endfunction

    // Queue random paths of assorted shapes, about n points in all
    task automatic add_paths(int n);
        int k, len, shape, ux, uy, nx, ny;
        bit [31:0] bx, by, px, py;
        k = 0;
        while (k < n) begin
            len = $urandom_range(1, 10);
            shape = $urandom_range(9);
            bx = $urandom; by = $urandom;
            ux = signed_rand(1 << $urandom_range(4, 22));
            uy = signed_rand(1 << $urandom_range(4, 22));
            px = bx; py = by;
            for (int i = 0; i < len; i++) begin
                if (shape <= 1) begin
                    px = $urandom; py = $urandom;
                end else if (shape <= 5) begin
                    px = px + signed_rand(1 << $urandom_range(0, 20));
                    py = py + signed_rand(1 << $urandom_range(0, 20));
                end else if (shape <= 8) begin
                    // near-straight line, deviation around the one degree mark
                    nx = signed_rand((ux < 0 ? -ux : ux) / 24 + (uy < 0 ? -uy : uy) / 24);
                    ny = signed_rand((ux < 0 ? -ux : ux) / 24 + (uy < 0 ? -uy : uy) / 24);
                    if (shape == 8 && $urandom_range(2) == 0) begin
                        nx = 0; ny = 0;
                    end
                    px = bx + i * ux + nx;
                    py = by + i * uy + ny;
                    if (shape == 8 && $urandom_range(3) == 0) begin
                        px = bx + (i - 1) * ux; py = by + (i - 1) * uy;
                    end
                end else begin
                    if ($urandom_range(1)) begin
                        px = px + signed_rand(3); py = py + signed_rand(3);
                    end
                end
                add_point(px, py, i == len - 1);
                k++;
            end
        end
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && expected_estimates.size() == 0 &&
              !s_axis_tvalid);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick(bit [31:0] lo, bit [31:0] hi, bit [31:0] usual);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return usual;
            default: return 32'(($urandom % (hi - lo + 64'd1)) + lo);
        endcase
    endfunction

    initial begin
        speed = 65536; turn_sec = 0; fixed_sec = 0;
        usable_sec = 65536; reserve = 0; capacity = 65536;
        clear_path();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed paths with reset settings
        add_point(32'h0000_1000, 32'h0000_2000, 1'b1);           // single point
        add_point(32'h8000_0000, 32'h8000_0000, 1'b0);           // extreme span
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        add_point(32'h0, 32'h0, 1'b0);                           // straight line
        add_point(32'h10000, 32'h0, 1'b0);
        add_point(32'h20000, 32'h0, 1'b0);
        add_point(32'h20000, 32'h0, 1'b0);                       // zero-length segment
        add_point(32'h30000, 32'h0, 1'b0);
        add_point(32'h30000, 32'h10000, 1'b0);                   // right angle
        add_point(32'h30000, 32'h0, 1'b0);                       // reversal
        add_point(32'h30000, 32'hFFFF_0000, 1'b1);
        add_point(32'h0, 32'h0, 1'b0);                           // just below one degree
        add_point(32'h100_0000, 32'h0, 1'b0);
        add_point(32'h200_0000, 32'h4_5000, 1'b0);
        add_point(32'h300_0000, 32'h8_E000, 1'b0);               // heading just above one degree off the x axis
        add_point(32'h400_0000, 32'hD_D000, 1'b1);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);           // zero-length path
        add_paths(30);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph == 3);
            if (ph == 0) begin
                cfg_write(pltbe_pkg::CFG_SPEED, 1);
                cfg_write(pltbe_pkg::CFG_TURN_SEC, 0);
                cfg_write(pltbe_pkg::CFG_TOL_SEC, 0);
                cfg_write(pltbe_pkg::CFG_USABLE, 1);
                cfg_write(pltbe_pkg::CFG_RESERVE, 0);
                cfg_write(pltbe_pkg::CFG_CAPACITY, 1);
            end else if (ph == 1) begin
                cfg_write(pltbe_pkg::CFG_SPEED, 32'hFF_FFFF);
                cfg_write(pltbe_pkg::CFG_TURN_SEC, 32'hFFFF_FFFF);
                cfg_write(pltbe_pkg::CFG_TOL_SEC, 32'hFFFF_FFFF);
                cfg_write(pltbe_pkg::CFG_USABLE, 32'hFFFF_FFFF);
                cfg_write(pltbe_pkg::CFG_RESERVE, 32'hFFFF);
                cfg_write(pltbe_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
            end else begin
                cfg_write(pltbe_pkg::CFG_SPEED, pick(1, 32'hFF_FFFF, 5 << 16));
                cfg_write(pltbe_pkg::CFG_TURN_SEC, pick(0, 32'hFFFF_FFFF, 2 << 16));
                cfg_write(pltbe_pkg::CFG_TOL_SEC, pick(0, 32'hFFFF_FFFF, 60 << 16));
                cfg_write(pltbe_pkg::CFG_USABLE, pick(1, 32'hFFFF_FFFF, 32'd1200 << 16));
                cfg_write(pltbe_pkg::CFG_RESERVE, pick(0, 32'hFFFF, 32'h3333));
                cfg_write(pltbe_pkg::CFG_CAPACITY, pick(1, 32'hFFFF_FFFF, 32'd80 << 16));
            end
            add_paths(40);
            drain();
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
